// ===== hdl/ferl_pkg.sv =====
// ----------------------------------------------------------------------------
// ferl_pkg
// Shared types and constants for the flash erase region lookup unit: request
// and response payloads, table entry layout, command and register codes,
// and the controller state encoding.
// ----------------------------------------------------------------------------
package ferl_pkg;

  // Table depth and derived widths
  localparam int MAX_REGIONS = 8;
  localparam int IDX_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CNT_W       = $clog2(MAX_REGIONS + 1);

  // Field widths
  localparam int ADDR_W      = 32;
  localparam int SPAN_W      = 42;
  localparam int UNITS_W     = 16;
  localparam int BLKCNT_W    = 16;
  localparam int UNIT_SHIFT  = 9;
  localparam int BYTES_W     = UNITS_W + UNIT_SHIFT;
  localparam int PROD_W      = UNITS_W + BLKCNT_W + 1;
  localparam int REGIDX_W    = 5;

  // Divider sizing: one quotient bit per step
  localparam int DIV_STEPS   = ADDR_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

  // Configuration port
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOT_PROTECT = 1'b1;

  // Commands
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef struct packed {
    logic                command;
    logic [REGIDX_W-1:0] region_index;
    logic [UNITS_W-1:0]  block_size_units;
    logic [BLKCNT_W-1:0] block_count_minus1;
    logic [ADDR_W-1:0]   address;
  } req_t;

  typedef struct packed {
    logic              found;
    logic [SPAN_W-1:0] block_start;
    logic [SPAN_W-1:0] block_end;
    logic              on_boundary;
    logic              boot_blocked;
  } rsp_t;

  typedef struct packed {
    logic [SPAN_W-1:0]  base;
    logic [SPAN_W-1:0]  limit;
    logic [BYTES_W-1:0] bytes;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LD_WRITE,
    ST_LK_READ,
    ST_LK_CHECK,
    ST_LK_DIV,
    ST_RESP
  } state_t;

endpackage

// ===== hdl/ferl_region_ram.sv =====
// ----------------------------------------------------------------------------
// ferl_region_ram
// Region table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ferl_region_ram (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [ferl_pkg::IDX_W-1:0]    wr_addr,
  input  ferl_pkg::entry_t              wr_data,
  input  logic                          rd_en,
  input  logic [ferl_pkg::IDX_W-1:0]    rd_addr,
  output ferl_pkg::entry_t              rd_data
);

  ferl_pkg::entry_t mem [ferl_pkg::MAX_REGIONS];

  // Write entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read entry; read data is registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/ferl_divider.sv =====
// ----------------------------------------------------------------------------
// ferl_divider
// Restoring divider that yields the remainder of a 32-bit offset divided by a
// block size, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ferl_divider (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            go,
  input  logic [ferl_pkg::ADDR_W-1:0]     dividend,
  input  logic [ferl_pkg::BYTES_W-1:0]    divisor,
  output logic                            done,
  output logic [ferl_pkg::BYTES_W-1:0]    remainder
);

  logic [ferl_pkg::ADDR_W-1:0]    dvd;
  logic [ferl_pkg::BYTES_W-1:0]   dsr;
  logic [ferl_pkg::BYTES_W-1:0]   rem;
  logic [ferl_pkg::BYTES_W-1:0]   rem_next;
  logic [ferl_pkg::BYTES_W:0]     trial;
  logic [ferl_pkg::DIV_CNT_W-1:0] cnt;
  logic                           running;

  // Shift in the next dividend bit and subtract when it fits
  always_comb begin
    trial = {rem, dvd[ferl_pkg::ADDR_W-1]};
    if (trial >= {1'b0, dsr}) begin
      rem_next = ferl_pkg::BYTES_W'(trial - {1'b0, dsr});
    end else begin
      rem_next = trial[ferl_pkg::BYTES_W-1:0];
    end
  end

  // Step control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == ferl_pkg::DIV_CNT_W'(ferl_pkg::DIV_STEPS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Operand and partial remainder
  always_ff @(posedge clk) begin
    if (go) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (running) begin
      dvd <= {dvd[ferl_pkg::ADDR_W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

  assign remainder = rem;

endmodule

// ===== hdl/flash_erase_region_lookup_unit.sv =====
// ----------------------------------------------------------------------------
// flash_erase_region_lookup_unit
// Flash erase region table with address lookup and boot-block protection.
// ----------------------------------------------------------------------------
// One request at a time: busy is high from the accepting edge through the
// response strobe cycle, so the next request is taken no earlier than the
// edge that ends the idle cycle after the strobe. A load passes through the
// table write state, then the strobe. A load whose index is past the table
// depth, and a lookup with no regions searched, go straight to the strobe.
// A lookup reads the region table one entry at a time (memory read, then
// compare) until a hit or the last searched region, then strobes. On a hit
// the remainder divider, one quotient bit per cycle, runs 32 quotient steps
// and then hands over the remainder before the strobe. Responses are
// presented for one cycle on rsp with rsp_valid high and cannot be stalled.
// Configuration writes are always ready and take effect at the next edge;
// write them only while the block is idle.
// ----------------------------------------------------------------------------
module flash_erase_region_lookup_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  ferl_pkg::req_t                    req,
  output logic                              rsp_valid,
  output ferl_pkg::rsp_t                    rsp,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ferl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ferl_pkg::CFG_DATA_W-1:0]   cfg_data
);

  ferl_pkg::state_t state, state_next;

  ferl_pkg::req_t                   req_q;
  ferl_pkg::rsp_t                   res;
  logic [ferl_pkg::PROD_W-1:0]      prod;
  logic [ferl_pkg::SPAN_W-1:0]      next_base;
  logic [ferl_pkg::CNT_W-1:0]       scan;
  logic [ferl_pkg::CNT_W-1:0]       nr;
  logic [ferl_pkg::BYTES_W-1:0]     bytes_q;
  logic [ferl_pkg::CFG_DATA_W-1:0]  region_count;
  logic                             boot_protect;

  logic                             accept;
  logic                             idx_ok;
  logic                             mem_wr_en;
  logic                             mem_rd_en;
  ferl_pkg::entry_t                 wr_entry;
  ferl_pkg::entry_t                 rd_entry;
  logic [ferl_pkg::SPAN_W-1:0]      ld_base;
  logic [ferl_pkg::SPAN_W-1:0]      addr_ext;
  logic                             hit;
  logic                             boot_hit;
  logic                             last_scan;
  logic                             div_go;
  logic                             div_done;
  logic [ferl_pkg::BYTES_W-1:0]     div_rem;
  logic [ferl_pkg::ADDR_W-1:0]      blk_start;
  logic [ferl_pkg::BLKCNT_W:0]      cnt_plus1;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign idx_ok    = req_q.region_index < ferl_pkg::REGIDX_W'(ferl_pkg::MAX_REGIONS);

  // Clamp the searched region count to the table depth
  assign nr = (region_count > ferl_pkg::CFG_DATA_W'(ferl_pkg::MAX_REGIONS))
            ? ferl_pkg::CNT_W'(ferl_pkg::MAX_REGIONS)
            : region_count[ferl_pkg::CNT_W-1:0];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      region_count <= '0;
      boot_protect <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ferl_pkg::CFG_REGION_COUNT: region_count <= cfg_data;
        ferl_pkg::CFG_BOOT_PROTECT: boot_protect <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Load entry: base chains from the last loaded region's limit unless index is zero
  assign ld_base = (req_q.region_index == '0) ? '0 : next_base;
  always_comb begin
    wr_entry.base  = ld_base;
    wr_entry.bytes = {req_q.block_size_units, {ferl_pkg::UNIT_SHIFT{1'b0}}};
    wr_entry.limit = ferl_pkg::SPAN_W'(ld_base + {prod, {ferl_pkg::UNIT_SHIFT{1'b0}}});
  end

  // Lookup compare on the entry just read
  assign addr_ext  = ferl_pkg::SPAN_W'(req_q.address);
  assign hit       = (addr_ext >= rd_entry.base) && (addr_ext < rd_entry.limit)
                     && (rd_entry.bytes != '0);
  assign boot_hit  = (addr_ext >= rd_entry.base) &&
                     ({1'b0, addr_ext} <
                      ({1'b0, rd_entry.base} + (ferl_pkg::SPAN_W + 1)'(rd_entry.bytes)));
  assign last_scan = ferl_pkg::CNT_W'(scan + 1'b1) == nr;
  assign blk_start = req_q.address - ferl_pkg::ADDR_W'(div_rem);
  assign cnt_plus1 = {1'b0, req.block_count_minus1} + 1'b1;

  ferl_region_ram u_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (req_q.region_index[ferl_pkg::IDX_W-1:0]),
    .wr_data (wr_entry),
    .rd_en   (mem_rd_en),
    .rd_addr (scan[ferl_pkg::IDX_W-1:0]),
    .rd_data (rd_entry)
  );

  ferl_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .go        (div_go),
    .dividend  (req_q.address - rd_entry.base[ferl_pkg::ADDR_W-1:0]),
    .divisor   (rd_entry.bytes),
    .done      (div_done),
    .remainder (div_rem)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ferl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ferl_pkg::ST_IDLE: begin
        if (accept) begin
          if (req.command == ferl_pkg::CMD_LOAD) begin
            state_next = (req.region_index < ferl_pkg::REGIDX_W'(ferl_pkg::MAX_REGIONS))
                       ? ferl_pkg::ST_LD_WRITE : ferl_pkg::ST_RESP;
          end else begin
            state_next = (nr == '0) ? ferl_pkg::ST_RESP : ferl_pkg::ST_LK_READ;
          end
        end
      end
      ferl_pkg::ST_LD_WRITE: state_next = ferl_pkg::ST_RESP;
      ferl_pkg::ST_LK_READ:  state_next = ferl_pkg::ST_LK_CHECK;
      ferl_pkg::ST_LK_CHECK: begin
        if (hit) begin
          state_next = ferl_pkg::ST_LK_DIV;
        end else if (last_scan) begin
          state_next = ferl_pkg::ST_RESP;
        end else begin
          state_next = ferl_pkg::ST_LK_READ;
        end
      end
      ferl_pkg::ST_LK_DIV: begin
        if (div_done) begin
          state_next = ferl_pkg::ST_RESP;
        end
      end
      ferl_pkg::ST_RESP: state_next = ferl_pkg::ST_IDLE;
      default:           state_next = ferl_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    busy      = 1'b1;
    rsp_valid = 1'b0;
    mem_wr_en = 1'b0;
    mem_rd_en = 1'b0;
    div_go    = 1'b0;
    unique case (state)
      ferl_pkg::ST_IDLE:     busy      = 1'b0;
      ferl_pkg::ST_LD_WRITE: mem_wr_en = idx_ok;
      ferl_pkg::ST_LK_READ:  mem_rd_en = 1'b1;
      ferl_pkg::ST_LK_CHECK: div_go    = hit;
      ferl_pkg::ST_LK_DIV:   ;
      ferl_pkg::ST_RESP:     rsp_valid = 1'b1;
      default:               ;
    endcase
  end

  // Chain base for the next load
  always_ff @(posedge clk) begin
    if (rst) begin
      next_base <= '0;
    end else if (mem_wr_en) begin
      next_base <= wr_entry.limit;
    end
  end

  // Request capture, scan index and response build
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
      prod  <= ferl_pkg::PROD_W'(req.block_size_units) *
               ferl_pkg::PROD_W'(cnt_plus1);
      scan  <= '0;
      // Clear the response; an empty table flags the boot block at once
      res   <= {1'b0, {ferl_pkg::SPAN_W{1'b0}}, {ferl_pkg::SPAN_W{1'b0}}, 1'b0,
                (req.command == ferl_pkg::CMD_LOOKUP) && boot_protect && (nr == '0)};
    end else if (state == ferl_pkg::ST_LK_CHECK) begin
      if (scan == '0) begin
        res.boot_blocked <= boot_protect && boot_hit;
      end
      if (hit) begin
        bytes_q <= rd_entry.bytes;
      end else begin
        scan <= ferl_pkg::CNT_W'(scan + 1'b1);
      end
    end else if ((state == ferl_pkg::ST_LK_DIV) && div_done) begin
      res.found       <= 1'b1;
      res.block_start <= ferl_pkg::SPAN_W'(blk_start);
      res.block_end   <= ferl_pkg::SPAN_W'(ferl_pkg::SPAN_W'(blk_start)
                                          + ferl_pkg::SPAN_W'(bytes_q));
      res.on_boundary <= (div_rem == '0);
    end
  end

  assign rsp = res;

endmodule

// ===== hdl/ferl_checker.sv =====
// ----------------------------------------------------------------------------
// ferl_checker
// Port-level checks for the flash erase region lookup unit, bound to the top.
// ----------------------------------------------------------------------------
module ferl_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           rsp_valid,
  input ferl_pkg::rsp_t rsp
);

  // An accepted request holds the unit busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  // A response strobe lasts a single cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |=> !rsp_valid)
    else $error("response strobe held for more than one cycle");

  // A response only closes a request in flight
  a_rsp_in_flight: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> busy)
    else $error("response without a request in flight");

  // A miss reports no block
  a_miss_clear: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.found |->
      (rsp.block_start == '0) && (rsp.block_end == '0) && !rsp.on_boundary)
    else $error("miss response carries block data");

  // A hit reports a non-empty block
  a_hit_span: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.found |-> rsp.block_end > rsp.block_start)
    else $error("hit response with an empty block");

endmodule

bind flash_erase_region_lookup_unit ferl_checker u_ferl_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .rsp_valid (rsp_valid),
  .rsp       (rsp)
);

// ===== sim/ferl_span_check.sv =====
// ----------------------------------------------------------------------------
// ferl_span_check
// Watches the request, response and configuration channels of the flash
// erase region lookup unit. Keeps its own copy of the region table and the
// register values, works out the span of every accepted request, and
// compares each response strobe field by field with the oldest span still
// awaited. Hands the mismatch count and the number of outstanding requests
// to the testbench top.
// ----------------------------------------------------------------------------
module ferl_span_check
  import ferl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  req_t                  req,
  input  logic                  rsp_valid,
  input  rsp_t                  rsp,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int unsigned           fail_count,
  output int unsigned           outstanding
);

  localparam logic [63:0] SPAN_MASK  = (64'd1 << SPAN_W) - 64'd1;
  localparam int unsigned PRINT_CAP  = 100;

  // Shadow region table and registers
  logic [SPAN_W-1:0]  tbl_base  [MAX_REGIONS];
  logic [SPAN_W-1:0]  tbl_end   [MAX_REGIONS];
  logic [BYTES_W-1:0] tbl_bytes [MAX_REGIONS];
  logic [SPAN_W-1:0]  nxt_base;
  logic [5:0]         rc;
  logic               bp;

  rsp_t        awaited_spans [$];
  rsp_t        want;
  int unsigned errs;

  // Apply one request to the shadow table and return the span it should produce
  function automatic rsp_t erase_span(input req_t r);
    rsp_t        o;
    logic [63:0] a;
    logic [63:0] base;
    logic [63:0] bytes;
    logic [63:0] lim;
    logic [63:0] st;
    int          nr;
    o = '0;
    a = 64'(r.address);
    if (r.command == CMD_LOAD) begin
      // Entries past the table depth are dropped without touching state
      if (r.region_index < MAX_REGIONS) begin
        base  = (r.region_index == 0) ? 64'd0 : 64'(nxt_base);
        bytes = 64'(r.block_size_units) << UNIT_SHIFT;
        lim   = (base + bytes * (64'(r.block_count_minus1) + 64'd1)) & SPAN_MASK;
        tbl_base[r.region_index[IDX_W-1:0]]  = base[SPAN_W-1:0];
        tbl_end[r.region_index[IDX_W-1:0]]   = lim[SPAN_W-1:0];
        tbl_bytes[r.region_index[IDX_W-1:0]] = bytes[BYTES_W-1:0];
        nxt_base = lim[SPAN_W-1:0];
      end
    end else begin
      nr = (rc > MAX_REGIONS) ? MAX_REGIONS : int'(rc);
      // First region holding the address wins; zero-size regions hold nothing
      for (int i = 0; i < nr; i++) begin
        base  = 64'(tbl_base[i]);
        bytes = 64'(tbl_bytes[i]);
        if (!o.found && bytes != 0 && a >= base && a < 64'(tbl_end[i])) begin
          st = (base + ((a - base) / bytes) * bytes) & SPAN_MASK;
          o.found       = 1'b1;
          o.block_start = st[SPAN_W-1:0];
          o.block_end   = SPAN_W'(st + bytes);
          o.on_boundary = (a == st);
        end
      end
      // Boot block is the first block of region 0, or everything when empty
      if (bp) begin
        o.boot_blocked = (nr == 0) ||
                         (a >= 64'(tbl_base[0]) &&
                          a < 64'(tbl_base[0]) + 64'(tbl_bytes[0]));
      end
    end
    return o;
  endfunction

  // Report one field; return 1 on a mismatch
  function automatic int unsigned field_diff(input string field,
                                             input logic [SPAN_W-1:0] exp_val,
                                             input logic [SPAN_W-1:0] act_val);
    if (exp_val !== act_val) begin
      // Keep the log readable when the block is badly broken
      if (errs < PRINT_CAP) begin
        $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                 $time, field, exp_val, act_val);
      end
      return 1;
    end
    return 0;
  endfunction

  // Track registers, compare responses, queue spans of accepted requests
  always @(posedge clk) begin
    if (rst) begin
      rc       = '0;
      bp       = 1'b1;
      nxt_base = '0;
      errs     = 0;
      awaited_spans.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_REGION_COUNT) begin
          rc = cfg_data;
        end else begin
          bp = cfg_data[0];
        end
      end
      if (rsp_valid) begin
        if (awaited_spans.size() == 0) begin
          if (errs < PRINT_CAP) begin
            $display("%0t: response with no request outstanding: expected none, actual %p",
                     $time, rsp);
          end
          errs++;
        end else begin
          want = awaited_spans.pop_front();
          errs += field_diff("found",        want.found,        rsp.found);
          errs += field_diff("block_start",  want.block_start,  rsp.block_start);
          errs += field_diff("block_end",    want.block_end,    rsp.block_end);
          errs += field_diff("on_boundary",  want.on_boundary,  rsp.on_boundary);
          errs += field_diff("boot_blocked", want.boot_blocked, rsp.boot_blocked);
        end
      end
      if (start && !busy) begin
        awaited_spans.push_back(erase_span(req));
      end
    end
    outstanding <= awaited_spans.size();
    fail_count  <= errs;
  end

endmodule

// ===== sim/tb_flash_erase_region_lookup_unit.sv =====
// ----------------------------------------------------------------------------
// tb_flash_erase_region_lookup_unit
// Drives the flash erase region lookup unit with a directed set of loads and
// lookups (empty table, zero-size and largest regions, ignored entries,
// clamped region count, boot block edges) followed by random phases of
// region reloads and aimed lookups under several register settings. The
// span checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_flash_erase_region_lookup_unit;
  import ferl_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1500;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam logic [63:0] SPAN_MASK    = (64'd1 << SPAN_W) - 64'd1;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  req_t                  req;
  logic                  rsp_valid;
  rsp_t                  rsp;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int unsigned           fail_count;
  int unsigned           outstanding;
  int unsigned           quiet_cycles;
  bit                    gaps_on;

  // Layout of the loaded table, kept only to aim lookup addresses
  logic [63:0] tgt_base   [MAX_REGIONS];
  logic [63:0] tgt_bytes  [MAX_REGIONS];
  logic [63:0] tgt_blocks [MAX_REGIONS];
  logic [63:0] tgt_next;

  flash_erase_region_lookup_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ferl_span_check span_check (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp         (rsp),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // End the run when nothing moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || rsp_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("flash_erase_region_lookup_unit test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Build a load request and note where the region lands
  function automatic req_t load_req(input logic [REGIDX_W-1:0] idx,
                                    input logic [UNITS_W-1:0] units,
                                    input logic [BLKCNT_W-1:0] cnt);
    req_t        r;
    logic [63:0] b;
    r.command            = CMD_LOAD;
    r.region_index       = idx;
    r.block_size_units   = units;
    r.block_count_minus1 = cnt;
    r.address            = $urandom;
    if (idx < MAX_REGIONS) begin
      b = (idx == 0) ? 64'd0 : tgt_next;
      tgt_base[idx[IDX_W-1:0]]   = b;
      tgt_bytes[idx[IDX_W-1:0]]  = 64'(units) << UNIT_SHIFT;
      tgt_blocks[idx[IDX_W-1:0]] = 64'(cnt) + 64'd1;
      tgt_next = (b + tgt_bytes[idx[IDX_W-1:0]] * tgt_blocks[idx[IDX_W-1:0]]) & SPAN_MASK;
    end
    return r;
  endfunction

  // Build a lookup request; unused fields carry random bits
  function automatic req_t lookup_req(input logic [ADDR_W-1:0] addr);
    req_t r;
    r.command            = CMD_LOOKUP;
    r.region_index       = REGIDX_W'($urandom);
    r.block_size_units   = UNITS_W'($urandom);
    r.block_count_minus1 = BLKCNT_W'($urandom);
    r.address            = addr;
    return r;
  endfunction

  // Pick an address on or near a block edge of some loaded region
  function automatic logic [ADDR_W-1:0] aim_address();
    int unsigned i;
    logic [63:0] q;
    logic [63:0] off;
    logic [63:0] a;
    i = $urandom_range(MAX_REGIONS - 1);
    case ($urandom_range(2))
      0:       q = 64'd0;
      1:       q = tgt_blocks[i] - 64'd1;
      default: q = 64'($urandom_range(0, tgt_blocks[i][31:0] - 1));
    endcase
    a = tgt_base[i] + q * tgt_bytes[i];
    if (tgt_bytes[i] != 0) begin
      case ($urandom_range(4))
        0:       off = 64'd0;
        1:       off = tgt_bytes[i] - 64'd1;
        2:       off = 64'($urandom) % tgt_bytes[i];
        3:       off = tgt_bytes[i];
        default: off = '1;
      endcase
      a = a + off;
    end
    return a[ADDR_W-1:0];
  endfunction

  // Present one request and hold it until accepted, idling first at random
  task automatic send_request(input req_t r);
    if (gaps_on && $urandom_range(99) < 33) begin
      start <= 1'b0;
      repeat (($urandom_range(9) == 0) ? $urandom_range(10, 70) : $urandom_range(1, 3))
        @(posedge clk);
    end
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and wait until every outstanding request has its response
  task automatic quiesce();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  // Write the selected registers, one handshake each
  task automatic program_regs(input bit wr_count, input logic [5:0] count,
                              input bit wr_prot, input logic prot);
    if (wr_count) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_REGION_COUNT;
      cfg_data  <= count;
      do @(posedge clk); while (!cfg_ready);
    end
    if (wr_prot) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_BOOT_PROTECT;
      cfg_data  <= {5'($urandom), prot};
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [UNITS_W-1:0] pick_units();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return UNITS_W'($urandom);
      default: return UNITS_W'($urandom_range(1, 64));
    endcase
  endfunction

  function automatic logic [BLKCNT_W-1:0] pick_count();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return BLKCNT_W'($urandom);
      default: return BLKCNT_W'($urandom_range(0, 15));
    endcase
  endfunction

  initial begin
    int unsigned sent;
    int unsigned phase;
    int unsigned n;
    int unsigned pick;
    logic [5:0]  count;

    rst       <= 1'b1;
    start     <= 1'b0;
    req       <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    gaps_on    = 1'b1;
    tgt_next   = '0;
    sent       = 0;
    phase      = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Empty table with boot protection on from reset, then off
    send_request(lookup_req(32'h0000_0000));
    send_request(lookup_req(32'hFFFF_FFFF));
    quiesce();
    program_regs(1'b0, '0, 1'b1, 1'b0);
    send_request(lookup_req(32'h0000_1234));

    // Fill every entry: small, zero-size, odd-size, largest, wrapping
    send_request(load_req(5'd0, 16'd8, 16'd3));
    send_request(load_req(5'd1, 16'd1, 16'd7));
    send_request(load_req(5'd2, 16'd0, 16'd5));
    send_request(load_req(5'd3, 16'd3, 16'hFFFF));
    send_request(load_req(5'd4, 16'hFFFF, 16'hFFFF));
    send_request(load_req(5'd5, 16'hFFFF, 16'hFFFF));
    send_request(load_req(5'd6, 16'd5, 16'd0));
    send_request(load_req(5'd7, 16'd1, 16'd0));
    // Entries past the table depth
    send_request(load_req(5'd8, 16'd1, 16'd1));
    send_request(load_req(5'd31, 16'hFFFF, 16'hFFFF));

    // Full table with protection on: boot block edges and each region
    quiesce();
    program_regs(1'b1, 6'd8, 1'b1, 1'b1);
    send_request(lookup_req(32'd0));
    send_request(lookup_req(32'd4095));
    send_request(lookup_req(32'd4096));
    send_request(lookup_req(32'd16897));
    send_request(lookup_req(32'd20480));
    send_request(lookup_req(32'd28167));
    send_request(lookup_req(32'hFFFF_FFFF));

    // Region count above the table depth clamps
    quiesce();
    program_regs(1'b1, 6'd63, 1'b1, 1'b0);
    send_request(lookup_req(32'hFFFF_FFFF));
    send_request(lookup_req(32'd100));

    // Two regions searched: miss past their end, boot block still flagged
    quiesce();
    program_regs(1'b1, 6'd2, 1'b1, 1'b1);
    send_request(lookup_req(32'd20480));
    send_request(lookup_req(32'd0));

    // Random phases: settle, reprogram, maybe reload, then a burst
    while (sent < RANDOM_ITEMS) begin
      phase++;
      quiesce();
      case ($urandom_range(5))
        0:       count = 6'd0;
        1:       count = 6'd8;
        2:       count = 6'd63;
        3:       count = 6'($urandom_range(1, 8));
        default: count = 6'($urandom_range(0, 63));
      endcase
      program_regs($urandom_range(3) != 0, count,
                   $urandom_range(1) == 1, 1'($urandom_range(1)));
      gaps_on = !(phase >= 10 && phase < 18);

      // Well-formed reload of the leading regions with random sizes
      if ($urandom_range(2) == 0) begin
        n = $urandom_range(1, MAX_REGIONS);
        for (int k = 0; k < n; k++) begin
          send_request(load_req(REGIDX_W'(k), pick_units(), pick_count()));
          sent++;
        end
      end

      repeat ($urandom_range(15, 40)) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          send_request(lookup_req(aim_address()));
          sent++;
        end else if (pick < 80) begin
          send_request(lookup_req($urandom));
          sent++;
        end else if (pick < 88) begin
          send_request(load_req(REGIDX_W'($urandom_range(1, MAX_REGIONS - 1)),
                                pick_units(), pick_count()));
          sent++;
        end else if (pick < 93) begin
          // Ignored by the block; not counted
          send_request(load_req(REGIDX_W'($urandom_range(MAX_REGIONS, 31)),
                                UNITS_W'($urandom), BLKCNT_W'($urandom)));
        end else begin
          send_request(load_req('0, pick_units(), pick_count()));
          sent++;
        end
      end
    end

    // Drain and let the block settle before the verdict
    quiesce();
    repeat (64) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("flash_erase_region_lookup_unit test passed");
    end else begin
      $display("flash_erase_region_lookup_unit test failed");
    end
    $finish;
  end

endmodule
